>>> hdl/qtie_pkg.sv
// shared types, constants and helpers for the quadtree image encoder
package qtie_pkg;

  localparam int MaxDepth  = 6;
  localparam int NodeCount = ((1 << (2 * (MaxDepth + 1))) - 1) / 3;
  localparam int AddrW     = $clog2(NodeCount);
  localparam int NodeW     = 11;
  localparam int DepthW    = 3;
  localparam int CoordW    = 6;

  typedef logic [AddrW-1:0] addr_t;

  typedef enum logic [1:0] {
    ActLoad  = 2'd0,
    ActBuild = 2'd1,
    ActFetch = 2'd2,
    ActNone  = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    StIdle,
    StBRd,
    StBAcc,
    StBWr,
    StCRd,
    StCWait,
    StCAcc,
    StBDone,
    StFRd,
    StFWait,
    StFOut,
    StOut
  } state_e;

  // first node index of a level: sum of the sizes of all levels above it
  function automatic addr_t level_first(input logic [3:0] lvl);
    addr_t acc;
    begin
      acc = '0;
      for (int i = 0; i <= MaxDepth; i++) begin
        if (4'(i) < lvl) acc = acc + addr_t'(1 << (2 * i));
      end
      level_first = acc;
    end
  endfunction

endpackage

>>> hdl/qtie_ram.sv
// generic single-port synchronous ram with registered read
module qtie_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

>>> hdl/quadtree_image_encoder.sv
// Quadtree image encoder top level: all node state lives in one single-port
// node ram (one access per cycle, registered read). A pixel load is written
// to the ram in the cycle it is accepted. A fetch reads the node, then its
// parent, and registers its result word; input is accepted again from the
// cycle after the result is taken. A build reduces each internal node bottom
// up (four child reads and one write), then runs a bit count pass over every
// node. Results wait in an output register until taken.
module quadtree_image_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action[1:0], pixel_x[7:2], pixel_y[13:8], pixel_value[21:14], zeros[23:22]
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // code_value[10:0], code_length[14:11], total_bits[30:15], zero[31]
  output logic [31:0] m_axis_tdata,
  // last_node
  output logic        m_axis_tlast
);
  import qtie_pkg::*;

  state_e st_q, st_d;
  logic [DepthW-1:0] cfg_q;
  addr_t pos_q, pos_d, idx_q, idx_d, end_q, end_d;
  logic [3:0] lvl_q, lvl_d;
  logic [2:0] k_q, k_d;
  logic [9:0] sum_q, sum_d;
  logic [7:0] m0_q, m0_d;
  logic uni_q, uni_d;
  logic [16:0] tot_q, tot_d;
  logic [NodeW-1:0] nd_q, nd_d;
  logic [10:0] ov_q, ov_d;
  logic [3:0] ol_q, ol_d;
  logic [15:0] ot_q, ot_d;
  logic olast_q, olast_d;
  logic fetch_q, fetch_d;

  logic we;
  addr_t addr;
  logic [NodeW-1:0] wdata, rdata;

  qtie_ram #(.Width(NodeW), .Depth(NodeCount)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  logic [3:0] depth;
  assign depth = (cfg_q > DepthW'(MaxDepth)) ? 4'(MaxDepth) : 4'(cfg_q);
  addr_t count;
  assign count = level_first(depth + 4'd1);

  logic [1:0] act;
  logic [CoordW-1:0] px, py;
  assign act = s_axis_tdata[1:0];
  assign px  = s_axis_tdata[7:2];
  assign py  = s_axis_tdata[13:8];

  // leaf offset: interleave quadrant digits msb first
  addr_t leaf_off;
  logic inside_img;
  always_comb begin
    logic [1:0] q;
    q = '0;
    leaf_off = '0;
    for (int b = MaxDepth; b > 0; b--) begin
      if (4'(b) <= depth) begin
        q = py[b-1] ? (px[b-1] ? 2'd2 : 2'd3) : (px[b-1] ? 2'd1 : 2'd0);
        leaf_off = addr_t'({leaf_off, q});
      end
    end
    inside_img = ((px >> depth) == '0) && ((py >> depth) == '0);
  end

  // code of a node from its entry, level, sibling position and parent uniform flag
  function automatic logic [14:0] code_of(input logic [NodeW-1:0] nd,
                                          input logic par_u, input logic root,
                                          input logic leaf, input logic fourth);
    logic [10:0] v;
    logic [3:0] n;
    begin
      v = '0;
      n = '0;
      if (!root && par_u) begin
        n = '0;
      end else if (root || !leaf) begin
        if (root || !fourth) begin
          v = 11'(nd[10:3]);
          n = 4'd8;
        end
        v = {v[8:0], nd[2:1]};
        n = n + 4'd2;
        if (nd[2:1] == 2'd0) begin
          v = {v[9:0], nd[0]};
          n = n + 4'd1;
        end
      end else if (!fourth) begin
        v = 11'(nd[10:3]);
        n = 4'd8;
      end
      code_of = {n, v};
    end
  endfunction

  logic [14:0] cd;
  logic cur_leaf;
  assign cur_leaf = (idx_q >= level_first(depth)) && (depth != 4'd0);
  assign cd = code_of(nd_q, rdata[0], idx_q == '0, cur_leaf, idx_q[1:0] == 2'b00);

  assign s_axis_tready = (st_q == StIdle) && !m_axis_tvalid;

  always_comb begin
    st_d = st_q; pos_d = pos_q; idx_d = idx_q; end_d = end_q; lvl_d = lvl_q;
    k_d = k_q; sum_d = sum_q; m0_d = m0_q; uni_d = uni_q; tot_d = tot_q;
    nd_d = nd_q; ov_d = ov_q; ol_d = ol_q; ot_d = ot_q; olast_d = olast_q;
    fetch_d = fetch_q;
    we = 1'b0; addr = idx_q; wdata = '0;
    case (st_q)
      StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          case (act)
            ActLoad: begin
              if (inside_img) begin
                we = 1'b1;
                addr = level_first(depth) + leaf_off;
                wdata = {s_axis_tdata[21:14], 3'b001};
              end
            end
            ActBuild: begin
              lvl_d = depth;
              tot_d = '0;
              if (depth == 4'd0) begin
                idx_d = '0; st_d = StCRd;
              end else begin
                idx_d = level_first(depth - 4'd1);
                end_d = level_first(depth);
                k_d = '0; sum_d = '0; uni_d = 1'b1;
                st_d = StBRd;
              end
            end
            ActFetch: begin
              if (pos_q < count) begin
                idx_d = pos_q; st_d = StFRd;
              end
            end
            default: ;
          endcase
        end
      end
      StBRd: begin
        addr = addr_t'({idx_q, 2'b00} + k_q + 1);
        st_d = StBAcc;
      end
      StBAcc: begin
        if (k_q == 3'd0) m0_d = rdata[10:3];
        sum_d = sum_q + 10'(rdata[10:3]);
        if (!rdata[0] || (k_q != 3'd0 && rdata[10:3] != m0_q)) uni_d = 1'b0;
        k_d = k_q + 3'd1;
        st_d = (k_q == 3'd3) ? StBWr : StBRd;
      end
      StBWr: begin
        we = 1'b1;
        addr = idx_q;
        wdata = uni_q ? {sum_q[9:2], 3'b001} : {sum_q[9:2], sum_q[1:0], 1'b0};
        k_d = '0; sum_d = '0; uni_d = 1'b1;
        if (idx_q + addr_t'(1) == end_q) begin
          if (lvl_q == 4'd1) begin
            idx_d = '0; st_d = StCRd;
          end else begin
            lvl_d = lvl_q - 4'd1;
            idx_d = level_first(lvl_q - 4'd2);
            end_d = level_first(lvl_q - 4'd1);
            st_d = StBRd;
          end
        end else begin
          idx_d = idx_q + addr_t'(1);
          st_d = StBRd;
        end
      end
      // counting pass and fetch share: read node, then parent
      StCRd, StFRd: begin
        addr = idx_q;
        st_d = (st_q == StCRd) ? StCWait : StFWait;
      end
      StCWait, StFWait: begin
        nd_d = rdata;
        addr = (idx_q == '0) ? '0 : addr_t'((idx_q - addr_t'(1)) >> 2);
        st_d = (st_q == StCWait) ? StCAcc : StFOut;
      end
      StCAcc: begin
        tot_d = tot_q + 17'(cd[14:11]);
        if (idx_q + addr_t'(1) == count) st_d = StBDone;
        else begin
          idx_d = idx_q + addr_t'(1); st_d = StCRd;
        end
      end
      StBDone: begin
        pos_d = '0;
        ov_d = '0; ol_d = '0; olast_d = 1'b0;
        ot_d = tot_q[16] ? 16'hFFFF : tot_q[15:0];
        st_d = StOut;
      end
      StFOut: begin
        ov_d = cd[10:0]; ol_d = cd[14:11]; ot_d = '0;
        olast_d = (idx_q + addr_t'(1) == count);
        pos_d = pos_q + addr_t'(1);
        st_d = StOut;
      end
      StOut: begin
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
    fetch_d = (st_q == StOut) ? 1'b1 : (m_axis_tvalid && m_axis_tready ? 1'b0 : fetch_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cfg_q <= DepthW'(MaxDepth); pos_q <= '0; fetch_q <= 1'b0;
    end else begin
      st_q <= st_d; pos_q <= pos_d; fetch_q <= fetch_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; end_q <= end_d; lvl_q <= lvl_d; k_q <= k_d; sum_q <= sum_d;
    m0_q <= m0_d; uni_q <= uni_d; tot_q <= tot_d; nd_q <= nd_d;
    ov_q <= ov_d; ol_q <= ol_d; ot_q <= ot_d; olast_q <= olast_d;
  end

  assign m_axis_tvalid = fetch_q;
  assign m_axis_tdata  = {1'b0, ot_q, ol_q, ov_q};
  assign m_axis_tlast  = olast_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word dropped while stalled");
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[14:11] <= 4'd11)
    else $error("code length out of range");
  a_notrdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != StIdle |-> !s_axis_tready)
    else $error("input accepted while busy");
endmodule
